// ===== rtl/multi_page_shelf_packer_macros.svh =====
// assertion macros shared by the shelf packer rtl
`ifndef MULTI_PAGE_SHELF_PACKER_MACROS_SVH
`define MULTI_PAGE_SHELF_PACKER_MACROS_SVH

// same-cycle implication, off during reset
`define MPSP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define MPSP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mpsp_pkg.sv =====
// types, constants and codes of the shelf packer
`timescale 1ns / 1ps
package mpsp_pkg;

  localparam int MAX_PAGES     = 8;
  localparam int MAX_DIMENSION = 4096;

  localparam int DIM_W      = 13;
  localparam int PAD_W      = 8;
  localparam int REQ_W      = DIM_W + 1;
  localparam int SUM_W      = DIM_W + 2;
  localparam int PAGE_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int OUT_PAGE_W = 3;
  localparam int COORD_W    = 12;
  localparam int STATUS_W   = 2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIM_W-1:0] DIM_SAT       = {DIM_W{1'b1}};
  localparam logic [DIM_W-1:0] PAGE_W_RESET  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] PAGE_H_RESET  = DIM_W'(1024);
  localparam logic [PAD_W-1:0] PAD_RESET     = '0;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED    = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_PAGE_WIDTH  = 2'd0,
    REG_PAGE_HEIGHT = 2'd1,
    REG_PAD         = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_FIT,
    S_OPEN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] page_width;
    logic [DIM_W-1:0] page_height;
    logic [PAD_W-1:0] pad;
  } cfg_t;

  typedef struct packed {
    logic              load_req;
    logic              do_wrap;
    logic              do_place;
    logic              do_open;
    logic              set_result;
    status_t           res_code;
    logic              load_out;
    logic [PAGE_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic             oversize;
    logic             wrap;
    logic             fits;
    logic [CNT_W-1:0] pages_used;
  } dp_sts_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_PAGE_W-1:0] page_index;
    logic [COORD_W-1:0]    place_x;
    logic [COORD_W-1:0]    place_y;
  } res_t;

endpackage

// ===== rtl/mpsp_if.sv =====
// valid/ready channel interfaces for requests and placements
`timescale 1ns / 1ps
interface mpsp_in_if;
  logic                       valid;
  logic                       ready;
  logic [mpsp_pkg::DIM_W-1:0] rect_width;
  logic [mpsp_pkg::DIM_W-1:0] rect_height;

  modport source (output valid, output rect_width, output rect_height, input ready);
  modport sink (input valid, input rect_width, input rect_height, output ready);
endinterface

interface mpsp_out_if;
  logic                            valid;
  logic                            ready;
  logic [mpsp_pkg::STATUS_W-1:0]   status;
  logic [mpsp_pkg::OUT_PAGE_W-1:0] page_index;
  logic [mpsp_pkg::COORD_W-1:0]    place_x;
  logic [mpsp_pkg::COORD_W-1:0]    place_y;

  modport source (output valid, output status, output page_index, output place_x,
                  output place_y, input ready);
  modport sink (input valid, input status, input page_index, input place_x,
                input place_y, output ready);
endinterface

// ===== rtl/mpsp_cfg.sv =====
// apb register block: page size and pad
`timescale 1ns / 1ps
module mpsp_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpsp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mpsp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mpsp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output mpsp_pkg::cfg_t                  cfg
);
  import mpsp_pkg::*;

  logic [DIM_W-1:0] page_width_r, page_width_nxt;
  logic [DIM_W-1:0] page_height_r, page_height_nxt;
  logic [PAD_W-1:0] pad_r, pad_nxt;
  logic             wr_en;
  reg_idx_t         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    page_width_nxt  = page_width_r;
    page_height_nxt = page_height_r;
    pad_nxt         = pad_r;
    prdata          = '0;
    case (reg_idx)
      REG_PAGE_WIDTH: begin
        prdata = CFG_DATA_W'(page_width_r);
        if (wr_en) begin
          page_width_nxt = pwdata[DIM_W-1:0];
        end
      end
      REG_PAGE_HEIGHT: begin
        prdata = CFG_DATA_W'(page_height_r);
        if (wr_en) begin
          page_height_nxt = pwdata[DIM_W-1:0];
        end
      end
      REG_PAD: begin
        prdata = CFG_DATA_W'(pad_r);
        if (wr_en) begin
          pad_nxt = pwdata[PAD_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_width_r  <= PAGE_W_RESET;
      page_height_r <= PAGE_H_RESET;
      pad_r         <= PAD_RESET;
    end else begin
      page_width_r  <= page_width_nxt;
      page_height_r <= page_height_nxt;
      pad_r         <= pad_nxt;
    end
  end

  assign cfg.page_width  = page_width_r;
  assign cfg.page_height = page_height_r;
  assign cfg.pad         = pad_r;
endmodule

// ===== rtl/mpsp_dp.sv =====
// datapath: per-page cursors, fit tests, result and output registers
`timescale 1ns / 1ps
module mpsp_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mpsp_pkg::cfg_t             cfg,
  input  logic [mpsp_pkg::DIM_W-1:0] rect_width,
  input  logic [mpsp_pkg::DIM_W-1:0] rect_height,
  input  mpsp_pkg::dp_cmd_t          cmd,
  output mpsp_pkg::dp_sts_t          sts,
  output mpsp_pkg::res_t             res_out
);
  import mpsp_pkg::*;

  logic [DIM_W-1:0] cx_r [MAX_PAGES];
  logic [DIM_W-1:0] cy_r [MAX_PAGES];
  logic [DIM_W-1:0] row_r [MAX_PAGES];
  logic [CNT_W-1:0] pages_used_r;

  logic [REQ_W-1:0] rw_r, rh_r;
  res_t             res_r, out_r;

  logic [DIM_W-1:0]  w_clamp, h_clamp;
  logic [DIM_W-1:0]  cur_cx, cur_cy, cur_row;
  logic [SUM_W-1:0]  x_end, y_end, wrap_sum, adv_sum;
  logic [DIM_W-1:0]  wrap_y, adv_x, new_row;
  logic [PAGE_W-1:0] open_idx;

  // page size clamp
  assign w_clamp = (int'(cfg.page_width) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION)
                                                          : cfg.page_width;
  assign h_clamp = (int'(cfg.page_height) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION)
                                                           : cfg.page_height;

  assign cur_cx  = cx_r[cmd.idx];
  assign cur_cy  = cy_r[cmd.idx];
  assign cur_row = row_r[cmd.idx];

  assign x_end    = SUM_W'(cur_cx) + SUM_W'(rw_r);
  assign y_end    = SUM_W'(cur_cy) + SUM_W'(rh_r);
  assign wrap_sum = SUM_W'(cur_cy) + SUM_W'(cur_row);
  assign adv_sum  = x_end;
  assign wrap_y   = (wrap_sum > SUM_W'(DIM_SAT)) ? DIM_SAT : wrap_sum[DIM_W-1:0];
  assign adv_x    = (adv_sum > SUM_W'(DIM_SAT)) ? DIM_SAT : adv_sum[DIM_W-1:0];
  // rh is bounded by the page height once the fit test passed
  assign new_row  = (rh_r > REQ_W'(cur_row)) ? rh_r[DIM_W-1:0] : cur_row;
  assign open_idx = PAGE_W'(pages_used_r);

  assign sts.oversize   = (rw_r > REQ_W'(w_clamp)) || (rh_r > REQ_W'(h_clamp));
  assign sts.wrap       = x_end > SUM_W'(w_clamp);
  assign sts.fits       = y_end <= SUM_W'(h_clamp);
  assign sts.pages_used = pages_used_r;

  // page state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PAGES; i++) begin
        cx_r[i]  <= '0;
        cy_r[i]  <= '0;
        row_r[i] <= '0;
      end
      pages_used_r <= '0;
    end else begin
      if (cmd.do_open) begin
        cx_r[open_idx]  <= '0;
        cy_r[open_idx]  <= '0;
        row_r[open_idx] <= '0;
        pages_used_r    <= pages_used_r + CNT_W'(1);
      end else if (cmd.do_wrap) begin
        cx_r[cmd.idx]  <= '0;
        cy_r[cmd.idx]  <= wrap_y;
        row_r[cmd.idx] <= '0;
      end else if (cmd.do_place) begin
        cx_r[cmd.idx]  <= adv_x;
        row_r[cmd.idx] <= new_row;
      end
    end
  end

  // request, result and output payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rw_r <= REQ_W'(rect_width) + REQ_W'(cfg.pad);
      rh_r <= REQ_W'(rect_height) + REQ_W'(cfg.pad);
    end
    if (cmd.set_result) begin
      res_r.status <= STATUS_W'(cmd.res_code);
      if (cmd.res_code == ST_EXHAUSTED) begin
        res_r.page_index <= '0;
      end else begin
        res_r.page_index <= OUT_PAGE_W'(cmd.idx);
      end
      if (cmd.res_code == ST_PLACED) begin
        res_r.place_x <= cur_cx[COORD_W-1:0];
        res_r.place_y <= cur_cy[COORD_W-1:0];
      end else begin
        res_r.place_x <= '0;
        res_r.place_y <= '0;
      end
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign res_out = out_r;
endmodule

// ===== rtl/mpsp_ctrl.sv =====
// controller: walks the pages in use, opens a fresh page, hands off results
`timescale 1ns / 1ps
module mpsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mpsp_pkg::dp_sts_t sts,
  output mpsp_pkg::dp_cmd_t cmd
);
  import mpsp_pkg::*;

  state_t            state_r, state_nxt;
  logic [PAGE_W-1:0] idx_r, idx_nxt;
  logic              fresh_r, fresh_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              more_pages;
  logic              all_used;

  assign more_pages = (CNT_W'(idx_r) + CNT_W'(1)) < sts.pages_used;
  assign all_used   = sts.pages_used == CNT_W'(MAX_PAGES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    fresh_nxt      = fresh_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_code   = ST_PLACED;
    cmd.idx        = idx_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          idx_nxt      = '0;
          fresh_nxt    = 1'b0;
          state_nxt    = (sts.pages_used == '0) ? S_OPEN : S_WRAP;
        end
      end
      S_WRAP, S_FIT: begin
        if (state_r == S_WRAP && !sts.oversize) begin
          cmd.do_wrap = sts.wrap;
          state_nxt   = S_FIT;
        end else if (state_r == S_FIT && sts.fits) begin
          cmd.do_place   = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_PLACED;
          state_nxt      = S_EMIT;
        end else if (fresh_r) begin
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_NO_SPACE;
          state_nxt      = S_EMIT;
        end else if (more_pages) begin
          idx_nxt   = idx_r + PAGE_W'(1);
          state_nxt = S_WRAP;
        end else if (all_used) begin
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_EXHAUSTED;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_OPEN;
        end
      end
      S_OPEN: begin
        cmd.do_open = 1'b1;
        idx_nxt     = PAGE_W'(sts.pages_used);
        fresh_nxt   = 1'b1;
        state_nxt   = S_WRAP;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ===== rtl/multi_page_shelf_packer.sv =====
// one page test is a wrap step then a height fit step on the shared cursor adders
// a page that the padded item cannot fit at all skips its fit step
// one item at a time: the next is accepted once the last result is in the output register
// the output register holds a result while the next item is accepted and worked on
// rst_n is synchronous, active low: cursors, page count, config and control registers reset
`timescale 1ns / 1ps
`include "multi_page_shelf_packer_macros.svh"
module multi_page_shelf_packer (
  input  logic                            clk,
  input  logic                            rst_n,
  mpsp_in_if.sink                         in_ch,
  mpsp_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpsp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mpsp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mpsp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mpsp_pkg::*;

  cfg_t    cfg;
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  res_t    res;

  // register block: page width, page height, pad
  mpsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: idle, per-page wrap and fit, fresh page open, result hand-off
  mpsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // cursors of every page, padded request, result and output registers
  mpsp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .rect_width  (in_ch.rect_width),
    .rect_height (in_ch.rect_height),
    .cmd         (dp_cmd),
    .sts         (dp_sts),
    .res_out     (res)
  );

  // output item fields
  assign out_ch.status     = res.status;
  assign out_ch.page_index = res.page_index;
  assign out_ch.place_x    = res.place_x;
  assign out_ch.place_y    = res.place_y;

  // one item in flight: no second accept right after an accept
  `MPSP_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "item accepted while another is in flight")

  // a rejected item carries no coordinates
  `MPSP_ASSERT_NOW(a_reject_zero_xy, clk, rst_n, out_ch.valid && out_ch.status != ST_PLACED, out_ch.place_x == '0 && out_ch.place_y == '0, "rejected item has nonzero coordinates")

  // exhaustion only once every page is open, and it reports page zero
  `MPSP_ASSERT_NOW(a_exhausted_full, clk, rst_n, out_ch.valid && out_ch.status == ST_EXHAUSTED, out_ch.page_index == '0 && dp_sts.pages_used == CNT_W'(MAX_PAGES), "pages exhausted reported with free pages")

  // page count never passes the page limit
  `MPSP_ASSERT_NOW(a_pages_bound, clk, rst_n, 1'b1, dp_sts.pages_used <= CNT_W'(MAX_PAGES), "page count beyond limit")
endmodule

// ===== bench/multi_page_shelf_packer_checker.sv =====
// placement predictor and result checker for the shelf packer bench
`timescale 1ns / 1ps
module multi_page_shelf_packer_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  mpsp_in_if                              req_mon,
  mpsp_out_if                             res_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [mpsp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mpsp_pkg::CFG_DATA_W-1:0] pwdata,
  output int unsigned                     mismatches,
  output int unsigned                     pending
);
  import mpsp_pkg::*;

  localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;

  // shadow registers
  logic [DIM_W-1:0] page_w_cfg;
  logic [DIM_W-1:0] page_h_cfg;
  logic [PAD_W-1:0] pad_cfg;

  // shadow shelf state, one entry per page
  logic [DIM_W-1:0] shelf_x   [MAX_PAGES];
  logic [DIM_W-1:0] shelf_y   [MAX_PAGES];
  logic [DIM_W-1:0] shelf_h   [MAX_PAGES];
  int unsigned      open_pages;

  res_t placement_q [$];

  function automatic int unsigned sat_dim(int unsigned v);
    return (v > DIM_MAX) ? DIM_MAX : v;
  endfunction

  // one page test: wrap if past the right edge (kept even on failure), then height fit
  function automatic bit fit_on_page(int unsigned p, int unsigned rw, int unsigned rh,
                                     output int unsigned px, output int unsigned py);
    int unsigned w;
    int unsigned h;
    w  = (page_w_cfg > MAX_DIMENSION) ? MAX_DIMENSION : page_w_cfg;
    h  = (page_h_cfg > MAX_DIMENSION) ? MAX_DIMENSION : page_h_cfg;
    px = 0;
    py = 0;
    if (rw > w || rh > h) return 1'b0;
    if (shelf_x[p] + rw > w) begin
      shelf_x[p] = '0;
      shelf_y[p] = DIM_W'(sat_dim(shelf_y[p] + shelf_h[p]));
      shelf_h[p] = '0;
    end
    if (shelf_y[p] + rh > h) return 1'b0;
    if (rh > shelf_h[p]) shelf_h[p] = DIM_W'(rh);
    px = shelf_x[p];
    py = shelf_y[p];
    shelf_x[p] = DIM_W'(sat_dim(shelf_x[p] + rw));
    return 1'b1;
  endfunction

  function automatic res_t place_rect(logic [DIM_W-1:0] rect_w, logic [DIM_W-1:0] rect_h);
    int unsigned rw;
    int unsigned rh;
    int unsigned px;
    int unsigned py;
    int unsigned p;
    int unsigned hit;
    bit          done;
    res_t        r;
    rw   = rect_w + pad_cfg;
    rh   = rect_h + pad_cfg;
    r    = '0;
    done = 1'b0;
    hit  = 0;
    for (p = 0; p < open_pages && !done; p++) begin
      if (fit_on_page(p, rw, rh, px, py)) begin
        done = 1'b1;
        hit  = p;
      end
    end
    if (done) begin
      r.status     = ST_PLACED;
      r.page_index = hit[OUT_PAGE_W-1:0];
      r.place_x    = px[COORD_W-1:0];
      r.place_y    = py[COORD_W-1:0];
    end else if (open_pages >= MAX_PAGES) begin
      r.status = ST_EXHAUSTED;
    end else begin
      hit          = open_pages;
      shelf_x[hit] = '0;
      shelf_y[hit] = '0;
      shelf_h[hit] = '0;
      open_pages++;
      r.page_index = hit[OUT_PAGE_W-1:0];
      if (fit_on_page(hit, rw, rh, px, py)) begin
        r.status  = ST_PLACED;
        r.place_x = px[COORD_W-1:0];
        r.place_y = py[COORD_W-1:0];
      end else begin
        r.status = ST_NO_SPACE;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      page_w_cfg = PAGE_W_RESET;
      page_h_cfg = PAGE_H_RESET;
      pad_cfg    = PAD_RESET;
      for (int i = 0; i < MAX_PAGES; i++) begin
        shelf_x[i] = '0;
        shelf_y[i] = '0;
        shelf_h[i] = '0;
      end
      open_pages = 0;
      placement_q.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_PAGE_WIDTH:  page_w_cfg = pwdata[DIM_W-1:0];
          REG_PAGE_HEIGHT: page_h_cfg = pwdata[DIM_W-1:0];
          REG_PAD:         pad_cfg    = pwdata[PAD_W-1:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        if (placement_q.size() == 0) begin
          $error("placement item with no request waiting");
          mismatches++;
        end else begin
          want = placement_q.pop_front();
          check_field("status", want.status, res_mon.status);
          check_field("page_index", want.page_index, res_mon.page_index);
          check_field("place_x", want.place_x, res_mon.place_x);
          check_field("place_y", want.place_y, res_mon.place_y);
        end
      end
      if (req_mon.valid && req_mon.ready)
        placement_q.push_back(place_rect(req_mon.rect_width, req_mon.rect_height));
    end
    pending = placement_q.size();
  end

endmodule

// ===== bench/multi_page_shelf_packer_test.sv =====
// top of the shelf packer bench: clock, reset, stimulus, register writes and verdict
`timescale 1ns / 1ps
module multi_page_shelf_packer_test;
  import mpsp_pkg::*;

  // the run guard leaves a wide margin over the worst correct run
  localparam int unsigned CYCLE_LIMIT = 400000;
  // wait after a drain, sized to cover the longest page walk of one item
  localparam int unsigned SETTLE_CYCLES = 24;

  typedef enum int {
    SZ_TINY,
    SZ_SMALL,
    SZ_MIXED
  } size_mix_t;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mpsp_in_if  in_ch ();
  mpsp_out_if out_ch ();

  int unsigned mismatches;
  int unsigned pending;

  // handshakes seen at the last rising edge, read at the falling edge
  logic in_took;
  logic cfg_took;

  int unsigned cycle_cnt;
  int unsigned burst_left;

  // receiver stall pattern state
  logic [15:0] stall_pat;
  int unsigned pat_left;

  multi_page_shelf_packer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  multi_page_shelf_packer_checker placement_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .res_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_took  <= in_ch.valid && in_ch.ready;
    cfg_took <= psel && penable && pwrite && pready;
  end

  // run guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: a new stall pattern each time the last one runs out, some of them all-ready
  always @(negedge clk) begin
    if (pat_left == 0) begin
      pat_left = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0:       stall_pat = 16'hFFFF;
        1:       stall_pat = 16'($urandom) | 16'h0001;
        2:       stall_pat = 16'hF0F0;
        default: stall_pat = 16'h8421;
      endcase
    end else begin
      pat_left--;
    end
    out_ch.ready <= stall_pat[pat_left % 16];
  end

  // random request size, mostly small so pages fill slowly
  function automatic logic [DIM_W-1:0] pick_dim(size_mix_t mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      SZ_TINY:  return DIM_W'($urandom_range(0, 2));
      SZ_SMALL: return DIM_W'((roll < 80) ? $urandom_range(0, 63) : $urandom_range(0, 511));
      default: begin
        if (roll < 60) return DIM_W'($urandom_range(0, 127));
        if (roll < 85) return DIM_W'($urandom_range(0, 1024));
        if (roll < 97) return DIM_W'($urandom_range(0, 4096));
        return DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
      end
    endcase
  endfunction

  // hold one request until the block takes it, valid stays up for back-to-back items
  task automatic push_rect(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    in_ch.valid       <= 1'b1;
    in_ch.rect_width  <= w;
    in_ch.rect_height <= h;
    do @(negedge clk); while (!in_took);
  endtask

  // sender bursts: after each burst a random gap, sometimes none at all
  task automatic pace();
    int unsigned gap;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // stop sending and wait until every placement has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // setup cycle then access cycle, psel left high so writes can run back to back
  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!cfg_took);
  endtask

  // registers only change with the block idle
  task automatic set_pages(int unsigned w, int unsigned h, int unsigned pd);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_PAGE_WIDTH, w);
    write_reg(REG_PAGE_HEIGHT, h);
    write_reg(REG_PAD, pd);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(int unsigned count, size_mix_t mix, bit hold_mid);
    for (int unsigned n = 0; n < count; n++) begin
      push_rect(pick_dim(mix), pick_dim(mix));
      pace();
      // sender holds off once until the pipe is empty
      if (hold_mid && n == count / 2) drain();
    end
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.rect_width  = '0;
    in_ch.rect_height = '0;
    out_ch.ready      = 1'b0;
    in_took           = 1'b0;
    cfg_took          = 1'b0;
    cycle_cnt         = 0;
    burst_left        = 1;
    stall_pat         = 16'hFFFF;
    pat_left          = 0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part at reset sizes 1024 x 1024, no pad
    push_rect(13'd0, 13'd0);       // zero size: opens page 0, cursor stays
    pace();
    push_rect(13'd1, 13'd1);
    pace();
    push_rect(13'd1024, 13'd1);    // full-width item wraps to a new row
    pace();
    push_rect(13'd1, 13'd1024);    // page 0 wraps then fails on height, page 1 opens
    pace();
    push_rect(13'd1023, 13'd1);    // lands on the row page 0 wrapped to
    pace();
    push_rect(13'd1025, 13'd1);    // too wide for an empty page: no space, page stays open
    pace();
    push_rect(13'd1, 13'd1025);    // too tall
    pace();
    push_rect(13'd4096, 13'd4096);
    pace();
    push_rect(13'h1FFF, 13'h1FFF); // all input bits set
    pace();
    push_rect(13'd1024, 13'd1024); // only an empty opened page can take it
    pace();
    push_rect(13'd0, 13'd4096);
    pace();
    push_rect(13'd5000, 13'd0);    // last free page opened and rejected
    pace();
    push_rect(13'd1, 13'd1);
    pace();
    push_rect(13'd2000, 13'd1);    // every page taken: exhausted
    pace();
    push_rect(13'd0, 13'd0);       // zero size still fits after exhaustion
    pace();

    // largest pages, small items, one drain in the middle
    set_pages(4096, 4096, 0);
    push_rect(13'd4096, 13'd1);
    pace();
    push_rect(13'd1, 13'd4096);
    pace();
    run_phase(150, SZ_SMALL, 1'b1);

    // maximum pad
    set_pages(4096, 4096, 255);
    push_rect(13'd3841, 13'd0);    // exactly the page width once padded
    pace();
    run_phase(100, SZ_SMALL, 1'b0);

    // smallest pages while cursors are far out: wraps and saturation
    set_pages(1, 1, 0);
    run_phase(30, SZ_TINY, 1'b0);

    // sizes beyond the limit are clamped
    set_pages(13'h1FFF, 6000, 17);
    run_phase(100, SZ_MIXED, 1'b0);

    set_pages($urandom_range(256, 4096), $urandom_range(256, 4096), $urandom_range(0, 255));
    run_phase(120, SZ_MIXED, 1'b0);

    set_pages(2048, 1024, 0);
    run_phase(100, SZ_MIXED, 1'b0);

    // let the last placements arrive and catch any stray ones
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mpsp_pkg.sv
rtl/mpsp_if.sv
rtl/mpsp_cfg.sv
rtl/mpsp_dp.sv
rtl/mpsp_ctrl.sv
rtl/multi_page_shelf_packer.sv
bench/multi_page_shelf_packer_checker.sv
bench/multi_page_shelf_packer_test.sv
